// ----- rtl/core/sih_pkg.sv -----
// shared types and constants for the string intern hash table
// no dependencies

package sih_pkg;

	localparam int TABLE_SIZE   = 1024;
	localparam int SLOT_W       = $clog2(TABLE_SIZE);
	localparam int CNT_W        = $clog2(TABLE_SIZE + 1);
	localparam int KEY_LEN_DEF  = 64;
	localparam int HASH_W       = 64;
	localparam int IDX_W        = 32;
	localparam int MULT_W       = 20;
	localparam logic [MULT_W-1:0] HASH_MULT = MULT_W'(1000003);
	localparam int PROBE_LIMIT  = TABLE_SIZE + 8;
	localparam int PROBE_W      = $clog2(PROBE_LIMIT + 1);
	localparam int FULL_W       = CNT_W + 2;
	localparam logic [FULL_W-1:0] FULL_MARK = FULL_W'(TABLE_SIZE * 2);

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_NEW   = 2'd1,
		ST_FULL  = 2'd2,
		ST_LONG  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] key_char;
		logic       last_char;
	} key_item_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_index;
		logic [CNT_W-1:0]  entry_count;
	} res_item_t;

	typedef struct packed {
		logic take_char;
		logic hash_step;
		logic probe_start;
		logic probe_step;
		logic latch_result;
		logic commit;
		logic clr_step;
	} sih_cmd_t;

	typedef struct packed {
		logic last_q;
		logic overflow;
		logic hit;
		logic bound;
		logic clr_last;
	} sih_sts_t;

endpackage

// ----- rtl/core/sih_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies

module sih_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/sih_ctrl.sv -----
// sequencer for hashing, probing, commit and the table clearing pass
// depends on sih_pkg

module sih_ctrl
	import sih_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     key_valid,
	output logic     key_ready,
	output logic     res_valid,
	input  logic     res_ready,
	input  sih_sts_t sts,
	output sih_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SUM   = 6'b000100,
		S_START = 6'b001000,
		S_PROBE = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign key_ready = (state_q == S_IDLE);
	assign res_valid = out_valid_q;
	assign out_free  = !out_valid_q || res_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (key_valid) begin
					cmd.take_char = 1'b1;
					state_d       = S_SUM;
				end
			end
			S_SUM: begin
				cmd.hash_step = 1'b1;
				state_d       = sts.last_q ? S_START : S_IDLE;
			end
			S_START: begin
				if (sts.overflow) begin
					cmd.latch_result = 1'b1;
					state_d          = S_DONE;
				end else begin
					cmd.probe_start = 1'b1;
					state_d         = S_PROBE;
				end
			end
			S_PROBE: begin
				if (sts.hit || sts.bound) begin
					cmd.latch_result = 1'b1;
					state_d          = S_DONE;
				end else begin
					cmd.probe_step = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a committed result shows on the output in the next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> res_valid)
		else $error("committed result not presented");

	// no character is taken while a key is being resolved
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE || state_q == S_DONE) |-> !cmd.take_char)
		else $error("character taken during probe");

endmodule

// ----- rtl/core/sih_dp.sv -----
// datapath: hash, key buffer, probe index, slot ram and result register
// depends on sih_pkg and sih_ram

module sih_dp
	import sih_pkg::*;
#(
	parameter int MAX_KEY_LEN = KEY_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  key_item_t key_item,
	input  sih_cmd_t  cmd,
	output sih_sts_t  sts,
	output res_item_t res_item
);

	localparam int LW     = $clog2(MAX_KEY_LEN + 1);
	localparam int KIW    = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
	localparam int CHAR_W = MAX_KEY_LEN * 8;
	localparam int WORD_W = 1 + HASH_W + LW + CHAR_W;
	localparam int P_LO_W = 32 + MULT_W;

	logic [HASH_W-1:0] hash_q, hash_base, hash_sum, probe_hash, h_q;
	logic [P_LO_W-1:0] p_lo_q;
	logic [31:0]       p_hi_q;
	logic [7:0]        char_q;
	logic              last_q;
	logic [LW-1:0]     len_q;
	logic              ovf_q;
	logic [7:0]        kbuf_q [MAX_KEY_LEN];
	logic [CHAR_W-1:0] kbuf_flat;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] clr_q;
	logic [IDX_W-1:0]  i_q, pert_q, i_next;
	logic [PROBE_W-1:0] n_q;
	status_t           stat_q;
	logic [SLOT_W-1:0] slot_q;
	logic [WORD_W-1:0] rd_word, wr_word;
	logic              we, re;
	logic [SLOT_W-1:0] waddr, raddr;
	logic              rd_occ, rd_match, hit, tbl_full;
	logic [HASH_W-1:0] rd_hash;
	logic [LW-1:0]     rd_len;
	logic [CHAR_W-1:0] rd_chars;
	logic [MAX_KEY_LEN-1:0] byte_eq;
	logic [FULL_W-1:0] cnt_x3;

	// hash input: the first character seeds the running value
	assign hash_base = (len_q == '0 && !ovf_q) ?
		{{(HASH_W-15){1'b0}}, key_item.key_char, 7'b0} : hash_q;
	assign hash_sum  = {p_hi_q, 32'b0} + {{(HASH_W-P_LO_W){1'b0}}, p_lo_q};
	assign probe_hash = hash_q ^ {{(HASH_W-LW){1'b0}}, len_q};
	assign i_next = {i_q[IDX_W-3:0], 2'b0} + i_q + pert_q + IDX_W'(1);

	always_comb begin
		for (int j = 0; j < MAX_KEY_LEN; j++) begin
			kbuf_flat[j*8 +: 8] = kbuf_q[j];
		end
	end

	assign {rd_occ, rd_hash, rd_len, rd_chars} = rd_word;

	always_comb begin
		for (int j = 0; j < MAX_KEY_LEN; j++) begin
			byte_eq[j] = (LW'(j) >= len_q) || (rd_chars[j*8 +: 8] == kbuf_flat[j*8 +: 8]);
		end
	end

	assign rd_match = (rd_hash == h_q) && (rd_len == len_q) && (&byte_eq);
	assign hit      = !rd_occ || rd_match;
	assign cnt_x3   = {2'b0, cnt_q} + {1'b0, cnt_q, 1'b0};
	assign tbl_full = (cnt_x3 >= FULL_MARK);

	assign sts.last_q   = last_q;
	assign sts.overflow = ovf_q;
	assign sts.hit      = hit;
	assign sts.bound    = !hit && (n_q == PROBE_W'(PROBE_LIMIT - 1));
	assign sts.clr_last = (clr_q == SLOT_W'(TABLE_SIZE - 1));

	assign wr_word = cmd.clr_step ? '0 : {1'b1, h_q, len_q, kbuf_flat};
	assign we      = cmd.clr_step || (cmd.commit && stat_q == ST_NEW);
	assign waddr   = cmd.clr_step ? clr_q : slot_q;
	assign re      = cmd.probe_start || cmd.probe_step;
	assign raddr   = cmd.probe_start ? probe_hash[SLOT_W-1:0] : i_next[SLOT_W-1:0];

	sih_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_SIZE)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_word),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (cmd.hash_step) begin
				hash_q <= hash_sum ^ {{(HASH_W-8){1'b0}}, char_q};
				if (len_q < LW'(MAX_KEY_LEN)) begin
					len_q <= len_q + LW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				hash_q <= '0;
				len_q  <= '0;
				ovf_q  <= 1'b0;
				if (stat_q == ST_NEW) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_char) begin
			char_q <= key_item.key_char;
			last_q <= key_item.last_char;
			p_lo_q <= P_LO_W'(hash_base[31:0] * HASH_MULT);
			p_hi_q <= 32'(hash_base[63:32] * HASH_MULT);
		end
		if (cmd.hash_step && len_q < LW'(MAX_KEY_LEN)) begin
			kbuf_q[len_q[KIW-1:0]] <= char_q;
		end
		if (cmd.probe_start) begin
			h_q    <= probe_hash;
			i_q    <= probe_hash[IDX_W-1:0];
			pert_q <= probe_hash[IDX_W-1:0];
			n_q    <= '0;
		end else if (cmd.probe_step) begin
			i_q    <= i_next;
			pert_q <= pert_q >> 5;
			n_q    <= n_q + PROBE_W'(1);
		end
		if (cmd.latch_result) begin
			slot_q <= i_q[SLOT_W-1:0];
			if (ovf_q) begin
				stat_q <= ST_LONG;
				slot_q <= '0;
			end else if (!hit) begin
				stat_q <= ST_FULL;
				slot_q <= '0;
			end else if (rd_occ) begin
				stat_q <= ST_FOUND;
			end else if (tbl_full) begin
				stat_q <= ST_FULL;
				slot_q <= '0;
			end else begin
				stat_q <= ST_NEW;
			end
		end
		if (cmd.commit) begin
			res_item.status      <= stat_q;
			res_item.slot_index  <= slot_q;
			res_item.entry_count <= (stat_q == ST_NEW) ? cnt_q + CNT_W'(1) : cnt_q;
		end
	end

	// an insert raises the occupancy by exactly one
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && stat_q == ST_NEW) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("occupancy not raised on insert");

	// occupancy never runs past the two-thirds refusal point
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x3 < FULL_MARK + FULL_W'(3))
		else $error("occupancy beyond refusal point");

	// key length stays within the buffer
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_KEY_LEN))
		else $error("key length beyond buffer");

endmodule

// ----- rtl/core/string_intern_hash_table.sv -----
// top level of the string intern hash table: controller plus datapath
// depends on sih_pkg, sih_ctrl, sih_dp, sih_ram

// channel | handshake            | item
// key     | key_valid/key_ready  | key_item: key_char, last_char
// res     | res_valid/res_ready  | res_item: status, slot_index, entry_count
//
// each character is accepted with the 32x20 partial products registered, then the
// 64-bit sum is formed and xored into the running hash
// after the final character a start state issues the first slot read, a probe state
// checks one slot per cycle (registered slot ram read), commit fills the result register
// after reset a clearing pass empties all TABLE_SIZE slots; key_ready stays low
// a result waiting on res_ready only stalls the next key at its commit

module string_intern_hash_table_core
	import sih_pkg::*;
#(
	parameter int MAX_KEY_LEN = KEY_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      key_valid,
	output logic      key_ready,
	input  key_item_t key_item,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_item
);

	// command and status between sequencer and datapath
	sih_cmd_t cmd;
	sih_sts_t sts;

	// sequencer: clearing pass, character hashing, probe walk, commit
	sih_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_valid(key_valid),
		.key_ready(key_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: hash, key buffer, slot ram and result register
	sih_dp #(
		.MAX_KEY_LEN(MAX_KEY_LEN)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_item(key_item),
		.cmd     (cmd),
		.sts     (sts),
		.res_item(res_item)
	);

endmodule
